/* rtl/core/iwaq_pkg.sv */
// Shared types and constants for the in-flight window ack queue.
// No dependencies; imported by iwaq_cell and inflight_window_ack_queue.
package iwaq_pkg;

    localparam int QUEUE_DEPTH_DEF  = 64;
    localparam int PUBLISH_CODE_DEF = 3;

    localparam int HANDLE_W = 16;
    localparam int IDENT_W  = 16;
    localparam int KIND_W   = 4;
    localparam int QOS_W    = 2;
    localparam int WIN_W    = 7;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 7'd16;

    localparam logic ACT_STORE = 1'b0;
    localparam logic ACT_ACK   = 1'b1;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [IDENT_W-1:0]  ident;
        logic [KIND_W-1:0]   kind;
        logic [QOS_W-1:0]    qos;
    } entry_t;

    typedef struct packed {
        logic write_en;
        logic shift_en;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_APPLY
    } state_t;

endpackage

/* rtl/core/iwaq_cell.sv */
// One queue slot: holds an entry, matches it against an ack key and takes
// its right neighbor's entry on a compaction shift. Depends on iwaq_pkg.
module iwaq_cell
    import iwaq_pkg::*;
#(
    parameter int IDX          = 0,
    parameter int CNT_W        = 7,
    parameter int PUBLISH_CODE = PUBLISH_CODE_DEF
) (
    input  logic             aclk,
    input  cell_ctl_t        ctl,
    input  entry_t           item_i,
    input  entry_t           nbr_i,
    input  logic [CNT_W-1:0] inflight_i,
    output entry_t           entry_o,
    output entry_t           tap_o,
    output logic             match_o
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   in_window;
    logic   key_hit;

    always_comb begin
        entry_next = entry_reg;
        if (ctl.shift_en) begin
            entry_next = nbr_i;
        end else if (ctl.write_en) begin
            entry_next = item_i;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    // only the front in-flight slots take part in an ack search
    assign in_window = inflight_i > CNT_W'(IDX);
    assign key_hit   = (entry_reg.ident == item_i.ident) && (entry_reg.kind == item_i.kind)
                       && ((item_i.kind != KIND_W'(PUBLISH_CODE))
                           || (entry_reg.qos == item_i.qos));

    assign match_o = in_window && key_hit;
    assign entry_o = entry_reg;
    // slot at the in-flight boundary is the next one to promote
    assign tap_o   = (inflight_i == CNT_W'(IDX)) ? entry_reg : '0;

endmodule

/* rtl/core/inflight_window_ack_queue.sv */
// Top level of the in-flight window ack queue: a row of iwaq_cell slots plus
// the count registers and control sequencer. Depends on iwaq_pkg, iwaq_cell.
//
// Usage:
//   s_* is the input channel (valid/ready). s_action selects a store (append
//   an entry at the tail) or an ack (remove the first in-flight entry that
//   matches ident and kind, and qos for publish). m_* carries one result per
//   item (valid/ready). cfg_wr_en/cfg_wr_data set the window size at once;
//   write it only while the block is idle.
//   Each item is latched, then the per-slot match vector and the promotion
//   tap are registered, and then the first-match isolation (a QUEUE_DEPTH-bit
//   add) and the slot shift are done; a new item is accepted only once the
//   previous one has left that last step.
//   The output register lets a new item be taken while a result waits; if
//   the receiver stalls, the item in flight holds in its last step until the
//   output register frees up, and no further item is accepted.
//   Reset clears the entry and in-flight counts and sets the window to 16.
//   Slot contents need no clearing; only written slots are ever read.
module inflight_window_ack_queue
    import iwaq_pkg::*;
#(
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
    parameter int PUBLISH_CODE = PUBLISH_CODE_DEF,
    parameter int CNT_W        = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [WIN_W-1:0]    cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_action,
    input  logic [HANDLE_W-1:0] s_msg_handle,
    input  logic [IDENT_W-1:0]  s_packet_ident,
    input  logic [KIND_W-1:0]   s_packet_kind,
    input  logic [QOS_W-1:0]    s_qos_level,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_dispatch,
    output logic                m_queue_full,
    output logic                m_ack_matched,
    output logic                m_publish_done,
    output logic                m_next_valid,
    output logic [HANDLE_W-1:0] m_next_handle,
    output logic [IDENT_W-1:0]  m_next_packet_ident,
    output logic [CNT_W-1:0]    m_entries_held
);

    localparam int CMP_W = (CNT_W > WIN_W) ? CNT_W : WIN_W;

    state_t state_reg, state_next;

    logic [WIN_W-1:0] window_reg;
    logic [CNT_W-1:0] entry_reg, entry_next;
    logic [CNT_W-1:0] inflight_reg, inflight_next;

    logic   action_reg;
    entry_t item_reg;

    logic [QUEUE_DEPTH-1:0] match_vec;
    logic [QUEUE_DEPTH-1:0] match_reg;
    logic [QUEUE_DEPTH-1:0] prefix;
    entry_t                 cell_q   [QUEUE_DEPTH];
    entry_t                 cell_tap [QUEUE_DEPTH];
    cell_ctl_t              cell_ctl [QUEUE_DEPTH];
    entry_t                 tap_or;
    entry_t                 promo_reg;

    logic s_fire;
    logic apply_go;
    logic found;
    logic is_full;
    logic send_ok;
    logic promote;

    logic                m_valid_reg;
    logic                dispatch_reg, queue_full_reg, ack_matched_reg, publish_done_reg;
    logic                next_valid_reg;
    logic [HANDLE_W-1:0] next_handle_reg;
    logic [IDENT_W-1:0]  next_ident_reg;
    logic [CNT_W-1:0]    held_reg;

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_fire) state_next = ST_MATCH;
            ST_MATCH: state_next = ST_APPLY;
            ST_APPLY: if (apply_go) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        apply_go = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_ready = 1'b1;
            ST_MATCH: ;
            ST_APPLY: apply_go = !m_valid_reg || m_ready;
            default:  ;
        endcase
    end

    assign s_fire = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            window_reg <= WINDOW_RESET;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                window_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            action_reg    <= s_action;
            item_reg      <= '{handle: s_msg_handle, ident: s_packet_ident,
                               kind: s_packet_kind, qos: s_qos_level};
        end
    end

    // ---------------- slot row ----------------
    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            entry_t nbr;
            if (gi == QUEUE_DEPTH - 1) begin : g_last
                assign nbr = cell_q[gi];
            end else begin : g_mid
                assign nbr = cell_q[gi+1];
            end

            assign cell_ctl[gi].shift_en = apply_go && (action_reg == ACT_ACK) && prefix[gi];
            assign cell_ctl[gi].write_en = apply_go && (action_reg == ACT_STORE) && !is_full
                                           && (entry_reg == CNT_W'(gi));

            iwaq_cell #(
                .IDX          (gi),
                .CNT_W        (CNT_W),
                .PUBLISH_CODE (PUBLISH_CODE)
            ) u_cell (
                .aclk       (aclk),
                .ctl        (cell_ctl[gi]),
                .item_i     (item_reg),
                .nbr_i      (nbr),
                .inflight_i (inflight_reg),
                .entry_o    (cell_q[gi]),
                .tap_o      (cell_tap[gi]),
                .match_o    (match_vec[gi])
            );
        end
    endgenerate

    always_comb begin
        tap_or = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            tap_or = tap_or | cell_tap[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_MATCH) begin
            match_reg <= match_vec;
            promo_reg <= tap_or;
        end
    end

    // slots at and above the first match: m | -m
    assign prefix = match_reg | ((~match_reg) + {{(QUEUE_DEPTH-1){1'b0}}, 1'b1});
    assign found  = |match_reg;

    // ---------------- counts ----------------
    assign is_full = entry_reg == CNT_W'(QUEUE_DEPTH);
    assign send_ok = (inflight_reg == entry_reg) && (CMP_W'(inflight_reg) < CMP_W'(window_reg));
    assign promote = entry_reg > inflight_reg;

    always_comb begin
        entry_next    = entry_reg;
        inflight_next = inflight_reg;
        if (apply_go) begin
            if (action_reg == ACT_STORE) begin
                if (!is_full) begin
                    entry_next = entry_reg + CNT_W'(1);
                    if (send_ok) begin
                        inflight_next = inflight_reg + CNT_W'(1);
                    end
                end
            end else if (found) begin
                entry_next = entry_reg - CNT_W'(1);
                // a promotion keeps the in-flight count where it was
                if (!promote) begin
                    inflight_next = inflight_reg - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg    <= '0;
            inflight_reg <= '0;
        end else begin
            entry_reg    <= entry_next;
            inflight_reg <= inflight_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (apply_go) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (apply_go) begin
            held_reg <= entry_next;
            if (action_reg == ACT_STORE) begin
                dispatch_reg     <= !is_full && send_ok;
                queue_full_reg   <= is_full;
                ack_matched_reg  <= 1'b0;
                publish_done_reg <= 1'b0;
                next_valid_reg   <= 1'b0;
                next_handle_reg  <= '0;
                next_ident_reg   <= '0;
            end else begin
                dispatch_reg     <= 1'b0;
                queue_full_reg   <= 1'b0;
                ack_matched_reg  <= found;
                publish_done_reg <= found && (item_reg.kind == KIND_W'(PUBLISH_CODE));
                next_valid_reg   <= found && promote;
                next_handle_reg  <= (found && promote) ? promo_reg.handle : '0;
                next_ident_reg   <= (found && promote) ? promo_reg.ident : '0;
            end
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_dispatch          = dispatch_reg;
    assign m_queue_full        = queue_full_reg;
    assign m_ack_matched       = ack_matched_reg;
    assign m_publish_done      = publish_done_reg;
    assign m_next_valid        = next_valid_reg;
    assign m_next_handle       = next_handle_reg;
    assign m_next_packet_ident = next_ident_reg;
    assign m_entries_held      = held_reg;

    // ---------------- assertions ----------------
    a_inflight_le_entries: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= entry_reg)
        else $error("in-flight count exceeds entry count");

    a_entries_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        entry_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count exceeds queue depth");

    a_match_then_apply: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MATCH) |=> (state_reg == ST_APPLY))
        else $error("match step not followed by apply step");

    a_counts_move_on_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !apply_go |=> $stable(entry_reg) && $stable(inflight_reg))
        else $error("counts changed without a result being produced");

    a_promote_needs_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && next_valid_reg |-> ack_matched_reg)
        else $error("promotion reported without a matched ack");

endmodule
